[src/skvt_pkg.sv]
// Shared types, widths and codes of the sorted key/value table.
`timescale 1ns / 1ps
`default_nettype none
package skvt_pkg;

	localparam int DEPTH = 64;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

	typedef logic signed [31:0] word_t;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_DELETE = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_BADRANK  = 3'd4;

	// Per-cell control, broadcast from the top with a few local terms
	typedef struct packed {
		logic ins;
		logic del;
		logic occ;
		logic left_lt;
		logic del_shift;
	} cell_ctl_t;

	// Per-cell compare results
	typedef struct packed {
		logic lt;
		logic eq;
		logic match;
	} cell_stat_t;

endpackage
`default_nettype wire

[src/skvt_if.sv]
// Request and result channel interfaces of the sorted key/value table.
`timescale 1ns / 1ps
`default_nettype none
interface skvt_req_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  req_type;
	logic signed [31:0] key;
	logic signed [31:0] value;
	logic signed [6:0]  rank;

	modport source (output valid, req_type, key, value, rank, input ready);
	modport sink   (input valid, req_type, key, value, rank, output ready);
endinterface

interface skvt_rsp_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  status;
	logic signed [31:0] value_out;
	logic signed [31:0] key_out;
	logic        [6:0]  entry_count;

	modport source (output valid, status, value_out, key_out, entry_count, input ready);
	modport sink   (input valid, status, value_out, key_out, entry_count, output ready);
endinterface
`default_nettype wire

[src/skvt_cell.sv]
// One table cell: holds one entry, compares it and shifts with its neighbours.
`timescale 1ns / 1ps
`default_nettype none
module skvt_cell
	import skvt_pkg::*;
(
	input  wire logic       clk,
	input  wire cell_ctl_t  ctl,
	input  wire word_t      key_new,
	input  wire word_t      value_new,
	input  wire word_t      left_key,
	input  wire word_t      left_value,
	input  wire word_t      right_key,
	input  wire word_t      right_value,
	output word_t           key_q,
	output word_t           value_q,
	output cell_stat_t      stat
);

	always_comb begin
		stat.lt    = ctl.occ && (key_q < key_new);
		stat.eq    = ctl.occ && (key_q == key_new);
		stat.match = ctl.occ && (value_q == value_new);
	end

	always_ff @(posedge clk) begin
		if (ctl.ins && !stat.lt) begin
			// first cell at or past the insert point takes the new entry, the rest move up
			if (ctl.left_lt) begin
				key_q   <= key_new;
				value_q <= value_new;
			end else begin
				key_q   <= left_key;
				value_q <= left_value;
			end
		end else if (ctl.del && ctl.del_shift) begin
			key_q   <= right_key;
			value_q <= right_value;
		end
	end

endmodule
`default_nettype wire

[src/sorted_key_value_table_core.sv]
// Top level of the sorted key/value table: row of cells, count and result register.
`timescale 1ns / 1ps
`default_nettype none
// Keeps up to DEPTH entries sorted by ascending signed key in a row of cells. Every
// request (insert, delete by value, read by rank) is decided and applied in the cycle
// it is accepted: all cells compare against the request at once and shift by one
// place towards or away from their neighbour. One request is taken per clock; the
// result appears in the output register the cycle after acceptance, and a new request
// is taken while that register is empty or its result is being taken. No clearing
// pass is needed after reset: only cells below the entry count are ever read.
module sorted_key_value_table_core
	import skvt_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	skvt_req_if.sink    req,
	skvt_rsp_if.source  rsp
);

	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	logic [2:0]       status_q;
	word_t            value_out_q;
	word_t            key_out_q;

	word_t            key_a   [DEPTH];
	word_t            value_a [DEPTH];
	cell_stat_t       stat_a  [DEPTH];
	cell_ctl_t        ctl_a   [DEPTH];

	logic [DEPTH-1:0] lt_v;
	logic [DEPTH-1:0] eq_v;
	logic [DEPTH-1:0] match_v;
	logic [DEPTH-1:0] shift_v;
	logic [DEPTH-1:0] sel_v;

	logic             accept;
	logic             is_ins;
	logic             is_del;
	logic             dup;
	logic             full;
	logic             found;
	logic             ins_en;
	logic             del_en;
	logic             rank_last;
	logic             bad_rank;
	logic [CMP_W-1:0] rank_cmp;
	logic [CMP_W-1:0] count_cmp;
	logic [CNT_W-1:0] rd_idx;
	word_t            rd_key;
	word_t            rd_value;
	logic [2:0]       status_d;
	word_t            value_d;
	word_t            key_d;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W+6:0] count_ext;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign is_ins  = req.req_type == REQ_INSERT;
	assign is_del  = req.req_type == REQ_DELETE;

	assign dup    = |eq_v;
	assign found  = |match_v;
	assign full   = count_q == CNT_W'(DEPTH);
	assign ins_en = accept && is_ins && !dup && !full;
	assign del_en = accept && is_del && found;

	// bits at and above the first matching cell: match vector ORed with its two's complement
	assign shift_v = match_v | (~match_v + {{(DEPTH-1){1'b0}}, 1'b1});

	assign rank_last = req.rank == 7'h7F;
	assign rank_cmp  = CMP_W'({1'b0, req.rank[5:0]});
	assign count_cmp = CMP_W'(count_q);
	assign bad_rank  = rank_last ? (count_q == '0) : (req.rank[6] || (rank_cmp >= count_cmp));
	assign rd_idx    = rank_last ? (count_q - {{(CNT_W-1){1'b0}}, 1'b1})
	                             : CNT_W'(req.rank[5:0]);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

		assign lt_v[i]    = stat_a[i].lt;
		assign eq_v[i]    = stat_a[i].eq;
		assign match_v[i] = stat_a[i].match;
		assign sel_v[i]   = rd_idx == IDX;

		always_comb begin
			ctl_a[i].ins       = ins_en;
			ctl_a[i].del       = del_en;
			ctl_a[i].occ       = IDX < count_q;
			ctl_a[i].left_lt   = (i == 0) ? 1'b1 : lt_v[(i == 0) ? 0 : i - 1];
			ctl_a[i].del_shift = shift_v[i];
		end

		skvt_cell u_cell (
			.clk         (clk),
			.ctl         (ctl_a[i]),
			.key_new     (req.key),
			.value_new   (req.value),
			.left_key    (key_a[(i == 0) ? 0 : i - 1]),
			.left_value  (value_a[(i == 0) ? 0 : i - 1]),
			.right_key   (key_a[(i == DEPTH - 1) ? i : i + 1]),
			.right_value (value_a[(i == DEPTH - 1) ? i : i + 1]),
			.key_q       (key_a[i]),
			.value_q     (value_a[i]),
			.stat        (stat_a[i])
		);
	end

	// one-hot select of the read cell, reduced by AND-OR
	always_comb begin
		rd_key   = '0;
		rd_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_key   = rd_key   | (key_a[i]   & {32{sel_v[i]}});
			rd_value = rd_value | (value_a[i] & {32{sel_v[i]}});
		end
	end

	always_comb begin
		status_d = ST_OK;
		value_d  = '0;
		key_d    = '0;
		count_d  = count_q;
		case (req.req_type)
			REQ_INSERT: begin
				if (dup) begin
					status_d = ST_DUP;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + {{(CNT_W-1){1'b0}}, 1'b1};
				end
			end
			REQ_DELETE: begin
				if (!found) begin
					status_d = ST_NOTFOUND;
				end else begin
					count_d = count_q - {{(CNT_W-1){1'b0}}, 1'b1};
				end
			end
			REQ_READ: begin
				if (bad_rank) begin
					status_d = ST_BADRANK;
					value_d  = '1;
					key_d    = '1;
				end else begin
					value_d = rd_value;
					key_d   = rd_key;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// hold the result until taken
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			value_out_q <= value_d;
			key_out_q   <= key_d;
		end
	end

	assign count_ext       = {7'd0, count_q};
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.value_out   = value_out_q;
	assign rsp.key_out     = key_out_q;
	assign rsp.entry_count = count_ext[6:0];

endmodule
`default_nettype wire

[verif/sorted_key_value_table_core_tb.sv]
// Testbench for sorted_key_value_table_core: directed and random requests checked against a table model.
`timescale 1ns / 1ps
module sorted_key_value_table_core_tb;
	import skvt_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic signed [6:0] RANK_LAST = -7'sd1;
	localparam int RANDOM_ITEMS = 1600;

	typedef struct packed {
		logic [2:0]  status;
		word_t       value_out;
		word_t       key_out;
		logic [6:0]  entry_count;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	skvt_req_if req_ch ();
	skvt_rsp_if rsp_ch ();

	sorted_key_value_table_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// Model of the table contents, kept in ascending key order
	word_t table_keys[$];
	word_t table_vals[$];
	table_result_t pending_results[$];
	int fail_count = 0;
	int burst_left = 0;
	int items_sent = 0;

	always #2 clk = ~clk;

	initial begin
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_INSERT;
		req_ch.key = '0;
		req_ch.value = '0;
		req_ch.rank = '0;
		rsp_ch.ready = 1'b0;
	end

	// Work out the result of one request and update the table model
	function automatic table_result_t apply_request(logic [1:0] rtype, word_t k, word_t v,
			logic signed [6:0] r);
		table_result_t res;
		int pos;
		int idx;
		bit hit;
		res = '{status: ST_OK, value_out: '0, key_out: '0, entry_count: '0};
		hit = 1'b0;
		pos = 0;
		idx = -1;
		case (rtype)
			REQ_INSERT: begin
				foreach (table_keys[i]) begin
					if (table_keys[i] == k)
						hit = 1'b1;
					if (table_keys[i] < k)
						pos = i + 1;
				end
				if (hit)
					res.status = ST_DUP;
				else if (table_keys.size() >= DEPTH)
					res.status = ST_FULL;
				else begin
					table_keys.insert(pos, k);
					table_vals.insert(pos, v);
				end
			end
			REQ_DELETE: begin
				foreach (table_vals[i]) begin
					if (!hit && table_vals[i] == v) begin
						hit = 1'b1;
						pos = i;
					end
				end
				if (!hit)
					res.status = ST_NOTFOUND;
				else begin
					table_keys.delete(pos);
					table_vals.delete(pos);
				end
			end
			REQ_READ: begin
				if (r == RANK_LAST)
					idx = table_keys.size() - 1;
				else if (r >= 0 && int'(r) < table_keys.size())
					idx = int'(r);
				if (idx < 0) begin
					res.status = ST_BADRANK;
					res.value_out = '1;
					res.key_out = '1;
				end else begin
					res.value_out = table_vals[idx];
					res.key_out = table_keys[idx];
				end
			end
			default: ;
		endcase
		res.entry_count = 7'(table_keys.size());
		return res;
	endfunction

	// Send one request, with bursts and random gaps on the request side
	task automatic send_request(input logic [1:0] rtype, input word_t k, input word_t v,
			input logic signed [6:0] r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				req_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rtype;
		req_ch.key <= k;
		req_ch.value <= v;
		req_ch.rank <= r;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(apply_request(rtype, k, v, r));
		items_sent++;
	endtask

	// Hold off new requests until every outstanding result has come back
	task automatic wait_results_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		burst_left = 0;
	endtask

	// Result side stalls on its own pattern: open stretches, random, long holds
	int stall_mode = 0;
	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(32, 256);
		end else
			stall_left <= stall_left - 1;
		case (stall_mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= $urandom_range(0, 1);
			2: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
			default: rsp_ch.ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	always @(posedge clk) begin : check_results
		table_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					fail_count++;
				end
				if (rsp_ch.value_out !== want.value_out) begin
					$error("value_out: expected %0d, got %0d", want.value_out,
						rsp_ch.value_out);
					fail_count++;
				end
				if (rsp_ch.key_out !== want.key_out) begin
					$error("key_out: expected %0d, got %0d", want.key_out, rsp_ch.key_out);
					fail_count++;
				end
				if (rsp_ch.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d", want.entry_count,
						rsp_ch.entry_count);
					fail_count++;
				end
			end
		end
	end

	task automatic test_empty_table();
		send_request(REQ_READ, '0, '0, 7'sd0);
		send_request(REQ_READ, '0, '0, RANK_LAST);
		send_request(REQ_READ, '0, '0, 7'sd63);
		send_request(REQ_READ, '0, '0, -7'sd64);
		send_request(REQ_DELETE, '0, 32'sd0, 7'sd0);
		send_request(REQ_UNUSED, '1, '1, RANK_LAST);
		wait_results_drained();
	endtask

	task automatic test_insert_extremes();
		send_request(REQ_INSERT, 32'h8000_0000, 32'sd5, 7'sd0);
		send_request(REQ_INSERT, 32'h7FFF_FFFF, -32'sd1, 7'sd0);
		send_request(REQ_INSERT, 32'sd0, 32'h8000_0000, 7'sd0);
		send_request(REQ_INSERT, -32'sd1, 32'h7FFF_FFFF, 7'sd0);
		// duplicate of the smallest key, then of the largest
		send_request(REQ_INSERT, 32'h8000_0000, 32'sd9, 7'sd0);
		send_request(REQ_INSERT, 32'h7FFF_FFFF, 32'sd9, 7'sd0);
		send_request(REQ_READ, '0, '0, 7'sd0);
		send_request(REQ_READ, '0, '0, RANK_LAST);
		send_request(REQ_READ, '0, '0, 7'sd3);
		send_request(REQ_READ, '0, '0, 7'sd4);
		send_request(REQ_READ, '0, '0, -7'sd64);
		send_request(REQ_UNUSED, 32'sd77, 32'sd5, 7'sd1);
		wait_results_drained();
	endtask

	task automatic test_delete_by_value();
		send_request(REQ_INSERT, 32'sd10, 32'sd7, 7'sd0);
		send_request(REQ_INSERT, -32'sd10, 32'sd7, 7'sd0);
		// first match in key order goes, so key -10 must leave
		send_request(REQ_DELETE, '0, 32'sd7, 7'sd0);
		send_request(REQ_READ, '0, '0, 7'sd2);
		send_request(REQ_DELETE, '0, 32'sd12345, 7'sd0);
		send_request(REQ_DELETE, '0, 32'h8000_0000, 7'sd0);
		send_request(REQ_READ, '0, '0, RANK_LAST);
		wait_results_drained();
	endtask

	task automatic test_full_table();
		int n;
		n = 0;
		while (table_keys.size() < DEPTH) begin
			send_request(REQ_INSERT, 32'sd1000 + n * 3, word_t'(n % 4), 7'sd0);
			n++;
		end
		send_request(REQ_INSERT, 32'sd2, 32'sd1, 7'sd0);
		// duplicate on a full table reports the duplicate
		send_request(REQ_INSERT, 32'sd1000, 32'sd1, 7'sd0);
		send_request(REQ_READ, '0, '0, 7'sd63);
		send_request(REQ_READ, '0, '0, RANK_LAST);
		send_request(REQ_READ, '0, '0, -7'sd64);
		send_request(REQ_DELETE, '0, 32'sd3, 7'sd0);
		send_request(REQ_INSERT, 32'h8000_0001, 32'sd3, 7'sd0);
		wait_results_drained();
	endtask

	function automatic word_t pick_key();
		case ($urandom_range(0, 9))
			0, 1, 2: return word_t'($urandom);
			3: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			4, 5: return (table_keys.size() != 0) ?
				table_keys[$urandom_range(0, table_keys.size() - 1)] : word_t'($urandom);
			default: return word_t'($urandom_range(0, 127)) - 32'sd64;
		endcase
	endfunction

	function automatic word_t pick_value();
		case ($urandom_range(0, 9))
			0, 1: return word_t'($urandom);
			2, 3, 4: return (table_vals.size() != 0) ?
				table_vals[$urandom_range(0, table_vals.size() - 1)] : word_t'($urandom);
			default: return word_t'($urandom_range(0, 15)) - 32'sd8;
		endcase
	endfunction

	function automatic logic signed [6:0] pick_rank();
		case ($urandom_range(0, 9))
			0, 1: return RANK_LAST;
			2, 3: return 7'($urandom);
			default: return (table_keys.size() > 1) ?
				7'($urandom_range(0, table_keys.size() - 1)) : 7'($urandom_range(0, 1));
		endcase
	endfunction

	task automatic test_random_traffic();
		int sent;
		int phase;
		int phase_len;
		int roll;
		logic [1:0] rtype;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			phase_len = $urandom_range(40, 200);
			phase = $urandom_range(0, 3);
			while (phase_len > 0 && sent < RANDOM_ITEMS) begin
				roll = $urandom_range(0, 99);
				case (phase)
					// fill, empty, read-heavy mix, raw noise
					0: rtype = (roll < 70) ? REQ_INSERT : (roll < 85) ? REQ_READ : REQ_DELETE;
					1: rtype = (roll < 70) ? REQ_DELETE : (roll < 85) ? REQ_READ : REQ_INSERT;
					2: rtype = (roll < 50) ? REQ_READ : (roll < 75) ? REQ_INSERT : REQ_DELETE;
					default: rtype = 2'($urandom);
				endcase
				if (phase == 3)
					send_request(rtype, word_t'($urandom), word_t'($urandom), 7'($urandom));
				else
					send_request(rtype, pick_key(), pick_value(), pick_rank());
				sent++;
				phase_len--;
			end
			if ($urandom_range(0, 2) == 0)
				wait_results_drained();
		end
		wait_results_drained();
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		test_empty_table();
		test_insert_extremes();
		test_delete_by_value();
		test_full_table();
		test_random_traffic();
		wait_results_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("** sorted_key_value_table_core: PASSED **");
		else
			$display("** sorted_key_value_table_core: FAILED **");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("** sorted_key_value_table_core: FAILED **");
		$finish;
	end

endmodule

[filelist.f]
src/skvt_pkg.sv
src/skvt_if.sv
src/skvt_cell.sv
src/sorted_key_value_table_core.sv
verif/sorted_key_value_table_core_tb.sv
